// ===== rtl/bidmap_pkg.sv =====
// Shared types and constants for the bidirectional ID remap table.
// Used by bidmap_table and bidirectional_id_remap_table_top; no dependencies.
package bidmap_pkg;

  localparam int CAP   = 64;
  localparam int IDX_W = $clog2(CAP);
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int ID_W  = 31;

  localparam logic [ID_W-1:0] ID_MAX    = 31'h7FFF_FFFF;
  localparam logic [31:0]     ID_MAX_32 = 32'h7FFF_FFFF;

  // operation codes
  localparam logic [2:0] OP_ALLOC      = 3'd0;
  localparam logic [2:0] OP_ADD        = 3'd1;
  localparam logic [2:0] OP_REMOVE     = 3'd2;
  localparam logic [2:0] OP_LOOKUP_FWD = 3'd3;
  localparam logic [2:0] OP_LOOKUP_REV = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FSTART,
    ST_FWAIT,
    ST_FEVAL,
    ST_RSTART,
    ST_RWAIT,
    ST_REVAL,
    ST_WRITE,
    ST_DONE
  } state_t;

  // one stored entry
  typedef struct packed {
    logic [ID_W-1:0] key;
    logic [ID_W-1:0] value;
  } tbl_entry_t;

  // outcome of one full scan of a table
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [ID_W-1:0]  value;
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;
  } scan_res_t;

  // write or invalidate command to a table
  typedef struct packed {
    logic             wr;
    logic             clr;
    logic [IDX_W-1:0] idx;
    logic [ID_W-1:0]  key;
    logic [ID_W-1:0]  value;
  } tbl_cmd_t;

endpackage

// ===== rtl/bidmap_table.sv =====
// One associative table: entry memory, valid bits and a linear key scan.
// Depends on bidmap_pkg.
module bidmap_table (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   scan_start,
  input  logic [bidmap_pkg::ID_W-1:0] scan_key,
  output logic                   scan_done,
  output bidmap_pkg::scan_res_t  scan_res,
  input  bidmap_pkg::tbl_cmd_t   cmd
);

  bidmap_pkg::tbl_entry_t mem [bidmap_pkg::CAP];
  bidmap_pkg::tbl_entry_t rd;
  logic [bidmap_pkg::CAP-1:0]   vld;
  logic [bidmap_pkg::IDX_W-1:0] idx;
  logic [bidmap_pkg::IDX_W-1:0] cidx;
  logic                         scanning;
  logic                         pend;
  logic                         last;

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[cmd.idx] <= '{key: cmd.key, value: cmd.value};
    end
    rd <= mem[idx];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.wr) begin
      vld[cmd.idx] <= 1'b1;
    end else if (cmd.clr) begin
      vld[cmd.idx] <= 1'b0;
    end
  end

  // scan: issue one address per cycle, compare the registered read data in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning  <= 1'b0;
      pend      <= 1'b0;
      scan_done <= 1'b0;
      last      <= 1'b0;
      idx       <= '0;
      cidx      <= '0;
      scan_res  <= '0;
    end else begin
      scan_done <= 1'b0;
      if (scan_start) begin
        scanning         <= 1'b1;
        pend             <= 1'b0;
        idx              <= '0;
        scan_res.hit     <= 1'b0;
        scan_res.free_ok <= 1'b0;
      end else begin
        pend <= scanning;
        if (scanning) begin
          cidx <= idx;
          last <= (idx == bidmap_pkg::IDX_W'(bidmap_pkg::CAP - 1));
          idx  <= idx + 1'b1;
          if (idx == bidmap_pkg::IDX_W'(bidmap_pkg::CAP - 1)) begin
            scanning <= 1'b0;
          end
        end
        if (pend) begin
          if (vld[cidx] && rd.key == scan_key && !scan_res.hit) begin
            scan_res.hit     <= 1'b1;
            scan_res.hit_idx <= cidx;
            scan_res.value   <= rd.value;
          end
          if (!vld[cidx] && !scan_res.free_ok) begin
            scan_res.free_ok  <= 1'b1;
            scan_res.free_idx <= cidx;
          end
          if (last) begin
            scan_done <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/bidirectional_id_remap_table_top.sv =====
// The result strobe follows one scan for a lookup, a remove without a nonzero value or
// an allocate that hits; both scans for other removes; both scans and ST_WRITE for
// allocate and explicit add. Set by the linear scans of the tables; a wrapping allocate
// adds one reverse scan per skipped ID; unused op codes strobe in the cycle after acceptance.
// One transaction at a time (busy high meanwhile), next accept in ST_IDLE after ST_DONE; results cannot stall.
// Reset (rst, synchronous): both tables empty at once, counter 1, init ID 0.
// Depends on bidmap_pkg and bidmap_table.
module bidirectional_id_remap_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op,
  input  logic [30:0] real_id,
  input  logic [30:0] virtual_id,
  output logic        done,
  output logic [30:0] result_id,
  output logic        status,
  output logic        is_init,
  output logic [30:0] init_real_id,
  output logic [6:0]  entry_count
);

  bidmap_pkg::state_t state, state_next;

  logic [2:0]                   op_r;
  logic [bidmap_pkg::ID_W-1:0]  rid_r, vid_r;
  logic [31:0]                  cand, cand_next;
  logic                         wrap_r, wrap_next;
  logic [bidmap_pkg::ID_W-1:0]  rkey, rkey_next;
  logic [bidmap_pkg::ID_W-1:0]  res_r, res_next;
  logic                         stat_r, stat_next;
  logic [31:0]                  next_virtual, next_virtual_next;
  logic [bidmap_pkg::ID_W-1:0]  init_real, init_real_next;
  logic [bidmap_pkg::CNT_W-1:0] count, count_next;

  logic                  f_start, r_start, f_done, r_done;
  bidmap_pkg::scan_res_t f_res, r_res;
  bidmap_pkg::tbl_cmd_t  f_cmd, r_cmd;
  logic [bidmap_pkg::ID_W-1:0] put_val;

  bidmap_table u_fwd (
    .clk(clk), .rst(rst), .scan_start(f_start), .scan_key(rid_r),
    .scan_done(f_done), .scan_res(f_res), .cmd(f_cmd)
  );

  bidmap_table u_rev (
    .clk(clk), .rst(rst), .scan_start(r_start), .scan_key(rkey),
    .scan_done(r_done), .scan_res(r_res), .cmd(r_cmd)
  );

  assign busy = (state != bidmap_pkg::ST_IDLE);

  // ports
  assign done         = (state == bidmap_pkg::ST_DONE);
  assign result_id    = res_r;
  assign status       = stat_r;
  assign is_init      = (init_real == rid_r);
  assign init_real_id = init_real;
  assign entry_count  = 7'(count);

  assign put_val = (op_r == bidmap_pkg::OP_ALLOC) ? cand[30:0] : vid_r;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bidmap_pkg::ST_IDLE: begin
        if (start) begin
          case (op)
            bidmap_pkg::OP_ALLOC, bidmap_pkg::OP_ADD, bidmap_pkg::OP_REMOVE,
            bidmap_pkg::OP_LOOKUP_FWD: state_next = bidmap_pkg::ST_FSTART;
            bidmap_pkg::OP_LOOKUP_REV: state_next = bidmap_pkg::ST_RSTART;
            default:                   state_next = bidmap_pkg::ST_DONE;
          endcase
        end
      end
      bidmap_pkg::ST_FSTART: state_next = bidmap_pkg::ST_FWAIT;
      bidmap_pkg::ST_FWAIT:  if (f_done) state_next = bidmap_pkg::ST_FEVAL;
      bidmap_pkg::ST_FEVAL: begin
        case (op_r)
          bidmap_pkg::OP_ALLOC:
            state_next = (f_res.hit && f_res.value != '0) ?
                         bidmap_pkg::ST_DONE : bidmap_pkg::ST_RSTART;
          bidmap_pkg::OP_ADD: state_next = bidmap_pkg::ST_RSTART;
          bidmap_pkg::OP_REMOVE:
            state_next = (f_res.hit && f_res.value != '0) ?
                         bidmap_pkg::ST_RSTART : bidmap_pkg::ST_DONE;
          default: state_next = bidmap_pkg::ST_DONE;
        endcase
      end
      bidmap_pkg::ST_RSTART: state_next = bidmap_pkg::ST_RWAIT;
      bidmap_pkg::ST_RWAIT:  if (r_done) state_next = bidmap_pkg::ST_REVAL;
      bidmap_pkg::ST_REVAL: begin
        case (op_r)
          bidmap_pkg::OP_ALLOC:
            if (wrap_r && r_res.hit && r_res.value != '0 &&
                cand < bidmap_pkg::ID_MAX_32) begin
              state_next = bidmap_pkg::ST_RSTART;
            end else begin
              state_next = bidmap_pkg::ST_WRITE;
            end
          bidmap_pkg::OP_ADD: state_next = bidmap_pkg::ST_WRITE;
          default:            state_next = bidmap_pkg::ST_DONE;
        endcase
      end
      bidmap_pkg::ST_WRITE: state_next = bidmap_pkg::ST_DONE;
      bidmap_pkg::ST_DONE:  state_next = bidmap_pkg::ST_IDLE;
      default:              state_next = bidmap_pkg::ST_IDLE;
    endcase
  end

  // datapath controls and next values
  always_comb begin
    f_start           = (state == bidmap_pkg::ST_FSTART);
    r_start           = (state == bidmap_pkg::ST_RSTART);
    f_cmd             = '0;
    r_cmd             = '0;
    cand_next         = cand;
    wrap_next         = wrap_r;
    rkey_next         = rkey;
    res_next          = res_r;
    stat_next         = stat_r;
    next_virtual_next = next_virtual;
    init_real_next    = init_real;
    count_next        = count;
    case (state)
      bidmap_pkg::ST_IDLE: begin
        res_next  = '0;
        stat_next = 1'b0;
        wrap_next = 1'b0;
        rkey_next = virtual_id;
      end
      bidmap_pkg::ST_FEVAL: begin
        case (op_r)
          bidmap_pkg::OP_ALLOC: begin
            if (f_res.hit && f_res.value != '0) begin
              res_next = f_res.value;
            end else if (next_virtual == '0 || next_virtual[31] ||
                         next_virtual[30:0] == bidmap_pkg::ID_MAX) begin
              // counter out of range: restart at 1 and skip IDs in use
              cand_next = 32'd1;
              wrap_next = 1'b1;
              rkey_next = 31'd1;
            end else begin
              cand_next = next_virtual;
              rkey_next = next_virtual[30:0];
            end
          end
          bidmap_pkg::OP_ADD: rkey_next = vid_r;
          bidmap_pkg::OP_REMOVE: begin
            if (f_res.hit) begin
              f_cmd.clr  = 1'b1;
              f_cmd.idx  = f_res.hit_idx;
              count_next = count - 1'b1;
              rkey_next  = f_res.value;
            end
          end
          bidmap_pkg::OP_LOOKUP_FWD: res_next = f_res.hit ? f_res.value : '0;
          default: ;
        endcase
      end
      bidmap_pkg::ST_REVAL: begin
        case (op_r)
          bidmap_pkg::OP_ALLOC: begin
            if (wrap_r && r_res.hit && r_res.value != '0 &&
                cand < bidmap_pkg::ID_MAX_32) begin
              cand_next = cand + 32'd1;
              rkey_next = cand[30:0] + 31'd1;
            end
          end
          bidmap_pkg::OP_REMOVE: begin
            if (r_res.hit) begin
              r_cmd.clr = 1'b1;
              r_cmd.idx = r_res.hit_idx;
            end
          end
          bidmap_pkg::OP_LOOKUP_REV: res_next = r_res.hit ? r_res.value : '0;
          default: ;
        endcase
      end
      bidmap_pkg::ST_WRITE: begin
        // forward put
        f_cmd.key   = rid_r;
        f_cmd.value = put_val;
        if (f_res.hit) begin
          f_cmd.wr  = 1'b1;
          f_cmd.idx = f_res.hit_idx;
        end else if (f_res.free_ok) begin
          f_cmd.wr   = 1'b1;
          f_cmd.idx  = f_res.free_idx;
          count_next = count + 1'b1;
        end
        // reverse put
        r_cmd.key   = put_val;
        r_cmd.value = rid_r;
        if (r_res.hit) begin
          r_cmd.wr  = 1'b1;
          r_cmd.idx = r_res.hit_idx;
        end else if (r_res.free_ok) begin
          r_cmd.wr  = 1'b1;
          r_cmd.idx = r_res.free_idx;
        end
        stat_next = (!f_res.hit && !f_res.free_ok) || (!r_res.hit && !r_res.free_ok);
        if (put_val == 31'd1) begin
          init_real_next = rid_r;
        end
        if (op_r == bidmap_pkg::OP_ALLOC) begin
          next_virtual_next = cand + 32'd1;
          res_next          = cand[30:0];
        end else if (next_virtual[31] || {1'b0, vid_r} >= next_virtual) begin
          next_virtual_next = {1'b0, vid_r} + 32'd1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bidmap_pkg::ST_IDLE;
      next_virtual <= 32'd1;
      init_real    <= '0;
      count        <= '0;
    end else begin
      state        <= state_next;
      next_virtual <= next_virtual_next;
      init_real    <= init_real_next;
      count        <= count_next;
    end
  end

  // transaction payload registers
  always_ff @(posedge clk) begin
    if (state == bidmap_pkg::ST_IDLE && start) begin
      op_r  <= op;
      rid_r <= real_id;
      vid_r <= virtual_id;
    end
    cand   <= cand_next;
    wrap_r <= wrap_next;
    rkey   <= rkey_next;
    res_r  <= res_next;
    stat_r <= stat_next;
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= bidmap_pkg::CNT_W'(bidmap_pkg::CAP))
    else $error("forward entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_fdone_wait: assert property (@(posedge clk) disable iff (rst)
    f_done |-> state == bidmap_pkg::ST_FWAIT)
    else $error("forward scan finished outside its wait state");

  a_rdone_wait: assert property (@(posedge clk) disable iff (rst)
    r_done |-> state == bidmap_pkg::ST_RWAIT)
    else $error("reverse scan finished outside its wait state");

endmodule
